// ===== src/u8u16_pkg.sv =====
// Shared types, constants and helper functions of the UTF-8 to UTF-16 path converter.
package u8u16_pkg;

	// Configuration register indexes.
	localparam logic CFG_OUTPUT_CAPACITY = 1'b0;
	localparam logic CFG_STOP_AT_NUL     = 1'b1;

	localparam logic [15:0] CAPACITY_RESET = 16'h8000;

	// Byte queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// UTF-16 constants.
	localparam logic [15:0] HIGH_SURROGATE = 16'hd800;
	localparam logic [15:0] LOW_SURROGATE  = 16'hdc00;
	localparam logic [20:0] PLANE_OFFSET   = 21'h10000;

	// UTF-8 lead byte bounds.
	localparam logic [7:0] LEAD2_LO      = 8'hc2;
	localparam logic [7:0] LEAD3_LO      = 8'he0;
	localparam logic [7:0] LEAD4_LO      = 8'hf0;
	localparam logic [7:0] LEAD4_HI      = 8'hf5;
	localparam logic [7:0] COPY_LO       = 8'ha0;
	localparam logic [7:0] LEAD3_MIN_2ND = 8'ha0;
	localparam logic [7:0] LEAD4_MIN_2ND = 8'h90;
	localparam logic [7:0] LEAD4_MAX     = 8'hf4;
	localparam logic [7:0] CONT_MASK     = 8'hc0;
	localparam logic [7:0] CONT_MARK     = 8'h80;
	localparam logic [7:0] PAYLOAD_MASK  = 8'h3f;

	localparam logic [7:0] CHAR_COLON      = 8'h3a;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CHAR_SLASH      = 8'h2f;
	localparam logic [7:0] CHAR_BACKSLASH  = 8'h5c;

	// One classified byte as it waits in the queue.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       ended;
		logic       nul_end;
	} entry_t;

	// Lowercase hex digit for a nibble.
	function automatic logic [15:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = 8'h30 + {4'd0, nib};
		end else begin
			ch = 8'h57 + {4'd0, nib};
		end
		return {8'd0, ch};
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_MARK;
	endfunction

endpackage

// ===== src/u8u16_if.sv =====
// Valid/ready channel interfaces for input bytes and output code units.
interface u8u16_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8u16_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        is_terminator;
	logic        overflow;
	logic [15:0] units_written;

	modport source (output valid, output code_unit, output is_terminator, output overflow,
		output units_written, input ready);
	modport sink (input valid, input code_unit, input is_terminator, input overflow,
		input units_written, output ready);
endinterface

// ===== src/utf8_to_utf16_path_converter.sv =====
// Top level of the UTF-8 to UTF-16 path converter: configuration registers, front and back.
//
// Usage:
// Bytes of a UTF-8 path enter on in_ch, one per transaction, with end_of_string on the
// last byte. UTF-16 code units leave on out_ch, one per transaction; each string closes
// with a terminator transaction carrying the overflow status and the unit count.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while the block is idle:
// index 0 sets output_capacity, index 1 sets stop_at_nul.
// Throughput: the front takes a byte every cycle into a four-entry queue while the queue
// is not full. The decoder loads one byte at a time from the queue and takes no further
// byte while it still has units to emit, which leave one at a time through its single
// output port. A decoded 4-byte sequence emits two units, and so does a hex escape when
// room is left for both.
// Reset clears the queue, the decoder state and the output valid flag, and sets capacity
// 32768 and stop_at_nul 1. When the receiver stalls, the result holds in the output
// register, the decoder halts, and the queue keeps taking bytes until it is full.
module utf8_to_utf16_path_converter (
	input  logic        clk,
	input  logic        arst_n,
	u8u16_in_if.sink    in_ch,
	u8u16_out_if.source out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [15:0]        capacity_q;
	logic               stop_at_nul_q;
	logic               q_valid;
	logic               q_pop;
	u8u16_pkg::entry_t  q_entry;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= u8u16_pkg::CAPACITY_RESET;
			stop_at_nul_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				u8u16_pkg::CFG_OUTPUT_CAPACITY: capacity_q    <= cfg_wdata;
				u8u16_pkg::CFG_STOP_AT_NUL:     stop_at_nul_q <= cfg_wdata[0];
			endcase
		end
	end

	u8u16_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.stop_at_nul (stop_at_nul_q),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop)
	);

	u8u16_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.output_capacity (capacity_q),
		.q_valid         (q_valid),
		.q_entry         (q_entry),
		.q_pop           (q_pop),
		.out_ch          (out_ch)
	);

endmodule

// ===== src/u8u16_front.sv =====
// Front end: accepts input bytes, classifies string ends and queues them for the decoder.
module u8u16_front (
	input  logic                  clk,
	input  logic                  arst_n,
	u8u16_in_if.sink              in_ch,
	input  logic                  stop_at_nul,
	output logic                  q_valid,
	output u8u16_pkg::entry_t     q_entry,
	input  logic                  q_pop
);

	u8u16_pkg::entry_t                  mem_q [u8u16_pkg::QUEUE_DEPTH];
	logic [u8u16_pkg::QUEUE_AW-1:0]     head_q;
	logic [u8u16_pkg::QUEUE_AW-1:0]     tail_q;
	logic [u8u16_pkg::QUEUE_AW:0]       count_q;
	logic                               push;
	logic                               pop;
	u8u16_pkg::entry_t                  new_entry;

	// Classify the byte: a zero byte ends the string when enabled.
	always_comb begin
		new_entry.in_byte = in_ch.in_byte;
		new_entry.nul_end = stop_at_nul && (in_ch.in_byte == 8'd0);
		new_entry.ended   = in_ch.end_of_string || new_entry.nul_end;
	end

	assign in_ch.ready = (count_q != (u8u16_pkg::QUEUE_AW+1)'(u8u16_pkg::QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (count_q != '0);
	assign pop         = q_pop && q_valid;
	assign q_entry     = mem_q[head_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= new_entry;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/u8u16_back.sv =====
// Back end: decodes buffered UTF-8 bytes into UTF-16 units, one unit at a time.
module u8u16_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [15:0]           output_capacity,
	input  logic                  q_valid,
	input  u8u16_pkg::entry_t     q_entry,
	output logic                  q_pop,
	u8u16_out_if.source           out_ch
);

	// Decoder state.
	logic             busy_q, busy_n;
	logic [3:0][7:0]  p_q, p_n;
	logic [2:0]       n_q, n_n;
	logic [15:0]      wpos_q, wpos_n;
	logic             ovf_q, ovf_n;
	logic             ended_q, ended_n;
	logic             pend_q, pend_n;
	logic [15:0]      pend_unit_q, pend_unit_n;

	// Output register.
	logic             out_valid_q;
	logic [15:0]      out_unit_q;
	logic             out_term_q;
	logic             out_ovf_q;
	logic [15:0]      out_cnt_q;

	logic             emit;
	logic [15:0]      e_unit;
	logic             e_term;
	logic             e_ovf;
	logic [15:0]      e_cnt;

	// Decode of the sequence at the head of the lookahead.
	logic [15:0]      limit;
	logic             slot_free;
	logic [7:0]       c;
	logic [1:0]       need;
	logic             short_seq;
	logic             ok2, ok3, ok4;
	logic [20:0]      scalar;
	logic [20:0]      v;
	logic [15:0]      first_unit;
	logic             second_needed;
	logic [15:0]      second_unit;
	logic [2:0]       used;
	logic [15:0]      wpos_inc;

	assign limit     = (output_capacity == 16'd0) ? 16'd0 : output_capacity - 16'd1;
	assign slot_free = !out_valid_q || out_ch.ready;
	assign c         = p_q[0];
	assign wpos_inc  = wpos_q + 16'd1;

	always_comb begin
		if (c >= u8u16_pkg::LEAD2_LO && c < u8u16_pkg::LEAD3_LO) begin
			need = 2'd1;
		end else if (c >= u8u16_pkg::LEAD3_LO && c < u8u16_pkg::LEAD4_LO) begin
			need = 2'd2;
		end else if (c >= u8u16_pkg::LEAD4_LO && c < u8u16_pkg::LEAD4_HI) begin
			need = 2'd3;
		end else begin
			need = 2'd0;
		end
		short_seq = (need != 2'd0) && (n_q <= {1'b0, need});

		ok2 = (need == 2'd1) && (n_q >= 3'd2) && u8u16_pkg::is_cont(p_q[1]);
		ok3 = (need == 2'd2) && (n_q >= 3'd3)
			&& !(c == u8u16_pkg::LEAD3_LO && p_q[1] < u8u16_pkg::LEAD3_MIN_2ND)
			&& u8u16_pkg::is_cont(p_q[1]) && u8u16_pkg::is_cont(p_q[2]);
		ok4 = (need == 2'd3) && (n_q >= 3'd4) && (wpos_inc < limit)
			&& !(c == u8u16_pkg::LEAD4_LO && p_q[1] < u8u16_pkg::LEAD4_MIN_2ND)
			&& !(c == u8u16_pkg::LEAD4_MAX && p_q[1] >= u8u16_pkg::LEAD4_MIN_2ND)
			&& u8u16_pkg::is_cont(p_q[1]) && u8u16_pkg::is_cont(p_q[2])
			&& u8u16_pkg::is_cont(p_q[3]);

		scalar = {c[2:0], p_q[1][5:0], p_q[2][5:0], p_q[3][5:0]};
		v      = scalar - u8u16_pkg::PLANE_OFFSET;

		second_needed = 1'b0;
		second_unit   = '0;
		used          = 3'd1;
		if (!c[7]) begin
			// ASCII with path separator mapping.
			if (c == u8u16_pkg::CHAR_COLON) begin
				first_unit = {8'd0, u8u16_pkg::CHAR_UNDERSCORE};
			end else if (c == u8u16_pkg::CHAR_SLASH) begin
				first_unit = {8'd0, u8u16_pkg::CHAR_BACKSLASH};
			end else begin
				first_unit = {8'd0, c};
			end
		end else if (ok2) begin
			first_unit = {5'd0, c[4:0], p_q[1][5:0]};
			used       = 3'd2;
		end else if (ok3) begin
			first_unit = {c[3:0], p_q[1][5:0], p_q[2][5:0]};
			used       = 3'd3;
		end else if (ok4) begin
			first_unit    = u8u16_pkg::HIGH_SURROGATE | {6'd0, v[19:10]};
			second_needed = 1'b1;
			second_unit   = u8u16_pkg::LOW_SURROGATE | {6'd0, v[9:0]};
			used          = 3'd4;
		end else if (c >= u8u16_pkg::COPY_LO) begin
			// Invalid lead copied as-is.
			first_unit = {8'd0, c};
		end else begin
			// Invalid lead escaped as two hex digits; the low one only if room is left.
			first_unit    = u8u16_pkg::hex_char(c[7:4]);
			second_needed = (wpos_inc < limit);
			second_unit   = u8u16_pkg::hex_char(c[3:0]);
		end
	end

	// Sequencer: load one byte, then step through the lookahead one unit at a time.
	always_comb begin
		busy_n      = busy_q;
		p_n         = p_q;
		n_n         = n_q;
		wpos_n      = wpos_q;
		ovf_n       = ovf_q;
		ended_n     = ended_q;
		pend_n      = pend_q;
		pend_unit_n = pend_unit_q;
		q_pop       = 1'b0;
		emit        = 1'b0;
		e_unit      = '0;
		e_term      = 1'b0;
		e_ovf       = 1'b0;
		e_cnt       = '0;

		if (!busy_q) begin
			if (q_valid) begin
				q_pop = 1'b1;
				if (ovf_q) begin
					// Discard the rest of an overflowed string.
					if (q_entry.ended) begin
						ovf_n  = 1'b0;
						n_n    = '0;
						wpos_n = '0;
					end
				end else begin
					busy_n  = 1'b1;
					ended_n = q_entry.ended;
					if (!q_entry.nul_end) begin
						p_n[n_q[1:0]] = q_entry.in_byte;
						n_n           = n_q + 3'd1;
					end
				end
			end
		end else if (pend_q) begin
			// Second unit of a surrogate pair or hex escape.
			if (slot_free) begin
				emit   = 1'b1;
				e_unit = pend_unit_q;
				wpos_n = wpos_inc;
				pend_n = 1'b0;
				if (n_q == 3'd0 && !ended_q) begin
					busy_n = 1'b0;
				end
			end
		end else if (n_q != 3'd0) begin
			if (wpos_q >= limit) begin
				// No room left: close the string with overflow.
				if (slot_free) begin
					emit   = 1'b1;
					e_term = 1'b1;
					e_ovf  = 1'b1;
					e_cnt  = wpos_q;
					n_n    = '0;
					wpos_n = '0;
					ovf_n  = !ended_q;
					busy_n = 1'b0;
				end
			end else if (short_seq && !ended_q) begin
				// Wait for more bytes of this sequence.
				busy_n = 1'b0;
			end else if (slot_free) begin
				emit        = 1'b1;
				e_unit      = first_unit;
				wpos_n      = wpos_inc;
				pend_n      = second_needed;
				pend_unit_n = second_unit;
				n_n         = n_q - used;
				for (int i = 0; i < 4; i++) begin
					if (3'(i) + used < 3'd4) begin
						p_n[i] = p_q[2'(3'(i) + used)];
					end else begin
						p_n[i] = 8'd0;
					end
				end
				if (!second_needed && n_n == 3'd0 && !ended_q) begin
					busy_n = 1'b0;
				end
			end
		end else if (ended_q) begin
			// Normal terminator.
			if (slot_free) begin
				emit   = 1'b1;
				e_term = 1'b1;
				e_cnt  = wpos_q;
				wpos_n = '0;
				busy_n = 1'b0;
			end
		end else begin
			busy_n = 1'b0;
		end
	end

	// Decoder control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			p_q     <= '0;
			n_q     <= '0;
			wpos_q  <= '0;
			ovf_q   <= 1'b0;
			ended_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			busy_q  <= busy_n;
			p_q     <= p_n;
			n_q     <= n_n;
			wpos_q  <= wpos_n;
			ovf_q   <= ovf_n;
			ended_q <= ended_n;
			pend_q  <= pend_n;
		end
	end

	always_ff @(posedge clk) begin
		pend_unit_q <= pend_unit_n;
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_unit_q <= e_unit;
			out_term_q <= e_term;
			out_ovf_q  <= e_ovf;
			out_cnt_q  <= e_cnt;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.code_unit     = out_unit_q;
	assign out_ch.is_terminator = out_term_q;
	assign out_ch.overflow      = out_ovf_q;
	assign out_ch.units_written = out_cnt_q;

endmodule

// ===== src/u8u16_checker.sv =====
// Port-level checks of the path converter and their binding to the top level.
module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_unit,
	input logic        is_terminator,
	input logic        overflow,
	input logic [15:0] units_written
);

	// A stalled transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit)
			&& $stable(is_terminator) && $stable(overflow) && $stable(units_written))
		else $error("output transaction changed while stalled");

	// Ordinary units carry no status.
	a_unit_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_terminator |-> !overflow && units_written == 16'd0)
		else $error("status fields set on a non-terminator unit");

	// The terminator carries a zero code unit.
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_terminator |-> code_unit == 16'd0)
		else $error("terminator with nonzero code unit");

endmodule

bind utf8_to_utf16_path_converter u8u16_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.code_unit     (out_ch.code_unit),
	.is_terminator (out_ch.is_terminator),
	.overflow      (out_ch.overflow),
	.units_written (out_ch.units_written)
);
